/* hdl/ordered_list_with_positional_delete_assert.svh */
// Assertion macros for the ordered list block.
`ifndef ORDERED_LIST_WITH_POSITIONAL_DELETE_ASSERT_SVH
`define ORDERED_LIST_WITH_POSITIONAL_DELETE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define OLPD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define OLPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OLPD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define OLPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hdl/olpd_pkg.sv */
// Package: action and status codes, controller states and cell commands.
package olpd_pkg;

  typedef enum logic [2:0] {
    ACT_APPEND    = 3'd0,
    ACT_DEL_HEAD  = 3'd1,
    ACT_DEL_TAIL  = 3'd2,
    ACT_DEL_AT    = 3'd3,
    ACT_DUMP      = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_BADPOS = 3'd2,
    ST_BEYOND = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_CLOSE,
    OP_ROTATE
  } cell_op_e;

endpackage

/* hdl/olpd_cell.sv */
// One storage cell of the list chain: holds one entry, loads, shifts or rotates.
module olpd_cell import olpd_pkg::*; #(
  parameter int INDEX = 0,
  parameter int IW    = 4
) (
  input  logic               clk_i,
  input  cell_op_e           op_i,
  input  logic [IW-1:0]      sel_i,
  input  logic [IW-1:0]      last_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] next_i,
  input  logic signed [31:0] head_i,
  output logic signed [31:0] data_o
);

  localparam logic [IW-1:0] MyIdx = IW'(INDEX);

  logic signed [31:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (op_i)
      OP_LOAD: begin
        if (sel_i == MyIdx) data_d = value_i;
      end
      OP_CLOSE: begin
        // take the neighbor's entry at and above the removed slot
        if (MyIdx >= sel_i) data_d = next_i;
      end
      OP_ROTATE: begin
        if (MyIdx == last_i) begin
          data_d = head_i;
        end else if (MyIdx < last_i) begin
          data_d = next_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* hdl/ordered_list_with_positional_delete.sv */
// Top level of the ordered list: controller, result register and the cell chain.
//
// Bounded ordered list of signed 32-bit values held in a chain of cells,
// entry 0 at the head. A command transfer happens at a rising edge with
// start_i high and busy_o low; action_i picks append, remove head, remove
// tail, remove at a 1-based position_i, or dump.
// Results come out on status_o, element_o and is_last_o, each for exactly
// one cycle marked by result_valid_o; the receiver cannot stall them.
// For append and the three removes the result shows the cycle after the
// transfer and busy_o stays low, so a command may follow in every cycle. A
// dump of N entries streams N results, one per cycle, once the controller has
// entered its dump state and the result register has taken the head, while
// the chain rotates its first N cells one step a cycle; busy_o rises at the
// transfer and drops as the tail result shows, so the next command can
// transfer at the edge that ends the tail cycle and the list is back in
// order by then. A dump of an empty list gives one result, the cycle after.
// Reset clears the entry count and the controller; the cells keep whatever
// they hold, and only entries below the count are ever read.
`include "ordered_list_with_positional_delete_assert.svh"

module ordered_list_with_positional_delete import olpd_pkg::*; #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         position_i,
  output logic               result_valid_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] element_o,
  output logic               is_last_o
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = $clog2(LIST_DEPTH);

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [IW-1:0]      dcnt_q, dcnt_d;
  logic               valid_q, valid_d;
  status_e            status_q, status_d;
  logic signed [31:0] element_q, element_d;
  logic               last_q, last_d;

  cell_op_e           cell_op;
  logic [IW-1:0]      cell_sel;
  logic [IW-1:0]      last_idx;
  logic               accept;
  logic               empty;
  logic               full;
  logic [7:0]         count8;

  logic signed [31:0] cell_data [LIST_DEPTH];
  logic signed [31:0] cell_next [LIST_DEPTH];

  assign accept   = start_i && (state_q == S_IDLE);
  assign empty    = (count_q == '0);
  assign full     = (count_q == CW'(LIST_DEPTH));
  assign count8   = 8'(count_q);
  // index of the tail; only used while the list holds at least one entry
  assign last_idx = IW'(count_q - 1'b1);

  // Next state: enter the dump only for a list that is not empty, leave on the tail.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (action_i == ACT_DUMP) && !empty) state_d = S_DUMP;
      end
      S_DUMP: begin
        if (dcnt_q == last_idx) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and result: decode the command, drive the chain, load the result register.
  always_comb begin
    cell_op   = OP_HOLD;
    cell_sel  = '0;
    count_d   = count_q;
    dcnt_d    = dcnt_q;
    valid_d   = 1'b0;
    status_d  = ST_OK;
    element_d = '0;
    last_d    = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          case (action_i)
            ACT_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                cell_op  = OP_LOAD;
                cell_sel = count_q[IW-1:0];
                count_d  = count_q + 1'b1;
              end
            end
            ACT_DEL_HEAD: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                cell_op  = OP_CLOSE;
                cell_sel = '0;
                count_d  = count_q - 1'b1;
              end
            end
            ACT_DEL_TAIL: begin
              // drop the tail by shrinking the count
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            ACT_DEL_AT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (position_i == '0) begin
                status_d = ST_BADPOS;
              end else if (position_i > count8) begin
                status_d = ST_BEYOND;
              end else begin
                cell_op  = OP_CLOSE;
                cell_sel = IW'(position_i - 8'd1);
                count_d  = count_q - 1'b1;
              end
            end
            ACT_DUMP: begin
              // empty list answers once; otherwise the dump state produces the stream
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                valid_d = 1'b0;
                dcnt_d  = '0;
              end
            end
            default: status_d = ST_OK;
          endcase
        end
      end
      S_DUMP: begin
        // emit the current head, then rotate the occupied cells one step
        valid_d   = 1'b1;
        element_d = cell_data[0];
        last_d    = (dcnt_q == last_idx);
        cell_op   = OP_ROTATE;
        dcnt_d    = dcnt_q + 1'b1;
      end
      default: cell_op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      dcnt_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      dcnt_q  <= dcnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    element_q <= element_d;
    last_q    <= last_d;
  end

  // Cell chain: each cell sees its upper neighbor; the top cell sees itself.
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    if (g < LIST_DEPTH - 1) begin : g_mid
      assign cell_next[g] = cell_data[g+1];
    end else begin : g_top
      assign cell_next[g] = cell_data[g];
    end

    olpd_cell #(
      .INDEX (g),
      .IW    (IW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .sel_i   (cell_sel),
      .last_i  (last_idx),
      .value_i (value_i),
      .next_i  (cell_next[g]),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  assign busy_o         = (state_q == S_DUMP);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign element_o      = element_q;
  assign is_last_o      = last_q;

  `OLPD_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(LIST_DEPTH), "entry count above list depth")
  `OLPD_ASSERT_NEXT(a_dump_streams, clk_i, rst_ni, state_q == S_DUMP, valid_q, "dump cycle without a result")
  `OLPD_ASSERT_NEXT(a_dump_keeps_count, clk_i, rst_ni, state_q == S_DUMP, count_q == $past(count_q), "count changed during dump")
  `OLPD_ASSERT_NOW(a_last_leaves_dump, clk_i, rst_ni, (state_q == S_DUMP) && (dcnt_q == last_idx), state_d == S_IDLE, "dump overran the tail")

endmodule
